// File: sv/wbit_pkg.sv
// ----------------------------------------------------------------------------
// wbit_pkg
// Shared codes, types and constants of the work/break interval timer.
// ----------------------------------------------------------------------------
`default_nettype none

package wbit_pkg;

  localparam int unsigned SEC_W   = 16;
  localparam int unsigned IDLE_W  = 32;
  localparam int unsigned THR_W   = 26;  // 65535 s * 1000 fits in 26 bits
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CIDX_W  = 2;

  localparam logic [SEC_W-1:0]  WORK_RST     = 16'd1500;
  localparam logic [SEC_W-1:0]  BREAK_RST    = 16'd300;
  localparam logic [SEC_W-1:0]  THRSEC_RST   = 16'd300;
  localparam logic [THR_W-1:0]  MS_PER_SEC   = 26'd1000;
  localparam logic [THR_W-1:0]  THR_RST      = 26'd300000;
  localparam logic [IDLE_W-1:0] IDLE_RES_MS  = 32'd2000;
  localparam logic [SEC_W-1:0]  COUNT_MAX    = 16'hFFFF;

  // Run states as seen on the result channel
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WORK  = 2'd1;
  localparam logic [1:0] ST_BREAK = 2'd2;
  localparam logic [1:0] ST_PAUSE = 2'd3;

  // Command codes
  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_START  = 3'd1;
  localparam logic [2:0] MODE_PAUSE  = 3'd2;
  localparam logic [2:0] MODE_RESUME = 3'd3;
  localparam logic [2:0] MODE_STOP   = 3'd4;
  localparam logic [2:0] MODE_SKIP   = 3'd5;
  localparam logic [2:0] MODE_RELOAD = 3'd6;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_WORK    = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_BREAK   = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_IDLE_EN = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_IDLE_TH = 2'd3;

  typedef struct packed {
    logic [SEC_W-1:0] work_seconds;
    logic [SEC_W-1:0] break_seconds;
    logic             idle_enable;
    logic [THR_W-1:0] idle_thr_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       cur_state;
    logic [1:0]       prev_state;
    logic [SEC_W-1:0] seconds_left;
    logic [SEC_W-1:0] phase_total;
    logic             paused_by_idle;
    logic             running;
    logic [SEC_W-1:0] completed;
    logic [SEC_W-1:0] skipped;
  } tstate_t;

  typedef struct packed {
    logic [1:0]       run_state;
    logic [SEC_W-1:0] remaining;
    logic [SEC_W-1:0] phase_length;
    logic             idle_paused;
    logic             work_done;
    logic             break_done;
    logic             idle_pause_event;
    logic             idle_resume_event;
    logic             skip_event;
    logic [SEC_W-1:0] breaks_completed;
    logic [SEC_W-1:0] breaks_skipped;
  } result_t;

endpackage

`default_nettype wire

// File: sv/wbit_if.sv
// ----------------------------------------------------------------------------
// wbit_in_if / wbit_out_if
// Valid/ready channels for commands and timer results.
// ----------------------------------------------------------------------------
`default_nettype none

interface wbit_in_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     mode;
  logic [wbit_pkg::IDLE_W-1:0]    idle_ms;

  modport source (output valid, output mode, output idle_ms, input ready);
  modport sink   (input valid, input mode, input idle_ms, output ready);
endinterface

interface wbit_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  run_state;
  logic [wbit_pkg::SEC_W-1:0]  remaining;
  logic [wbit_pkg::SEC_W-1:0]  phase_length;
  logic                        idle_paused;
  logic                        work_done;
  logic                        break_done;
  logic                        idle_pause_event;
  logic                        idle_resume_event;
  logic                        skip_event;
  logic [wbit_pkg::SEC_W-1:0]  breaks_completed;
  logic [wbit_pkg::SEC_W-1:0]  breaks_skipped;

  modport source (output valid, output run_state, output remaining, output phase_length,
                  output idle_paused, output work_done, output break_done,
                  output idle_pause_event, output idle_resume_event, output skip_event,
                  output breaks_completed, output breaks_skipped, input ready);
  modport sink   (input valid, input run_state, input remaining, input phase_length,
                  input idle_paused, input work_done, input break_done,
                  input idle_pause_event, input idle_resume_event, input skip_event,
                  input breaks_completed, input breaks_skipped, output ready);
endinterface

`default_nettype wire

// File: sv/wbit_step.sv
// ----------------------------------------------------------------------------
// wbit_step
// Next-state and result logic for one command applied to the timer state.
// ----------------------------------------------------------------------------
`default_nettype none

module wbit_step (
  input  wire wbit_pkg::tstate_t             st,
  input  wire wbit_pkg::cfg_t                cfg,
  input  wire logic [2:0]                    mode,
  input  wire logic [wbit_pkg::IDLE_W-1:0]   idle_ms,
  output wbit_pkg::tstate_t                  st_nxt,
  output wbit_pkg::result_t                  res
);

  wbit_pkg::tstate_t n;
  logic              wd;
  logic              bd;
  logic              ip_ev;
  logic              ir_ev;
  logic              sk_ev;
  logic [1:0]        resume_to;
  logic              idle_hit;
  logic              idle_gone;

  assign resume_to = (st.prev_state == wbit_pkg::ST_IDLE) ? wbit_pkg::ST_WORK : st.prev_state;
  assign idle_hit  = idle_ms >= {{(wbit_pkg::IDLE_W-wbit_pkg::THR_W){1'b0}}, cfg.idle_thr_ms};
  assign idle_gone = idle_ms < wbit_pkg::IDLE_RES_MS;

  always_comb begin
    n     = st;
    wd    = 1'b0;
    bd    = 1'b0;
    ip_ev = 1'b0;
    ir_ev = 1'b0;
    sk_ev = 1'b0;
    unique case (mode)
      wbit_pkg::MODE_TICK: begin
        if (st.running) begin
          if (cfg.idle_enable) begin
            if (st.cur_state == wbit_pkg::ST_WORK && idle_hit) begin
              n.paused_by_idle = 1'b1;
              n.prev_state     = st.cur_state;
              n.cur_state      = wbit_pkg::ST_PAUSE;
              ip_ev            = 1'b1;
            end else if (st.cur_state == wbit_pkg::ST_PAUSE && st.paused_by_idle &&
                         idle_gone) begin
              n.paused_by_idle = 1'b0;
              n.cur_state      = resume_to;
              ir_ev            = 1'b1;
            end
          end
          if (n.cur_state != wbit_pkg::ST_PAUSE) begin
            if (n.seconds_left != '0) begin
              n.seconds_left = n.seconds_left - 16'd1;
            end
            if (n.seconds_left == '0) begin
              if (n.cur_state == wbit_pkg::ST_WORK) begin
                if (st.completed != wbit_pkg::COUNT_MAX) begin
                  n.completed = st.completed + 16'd1;
                end
                wd             = 1'b1;
                n.phase_total  = cfg.break_seconds;
                n.seconds_left = cfg.break_seconds;
                n.cur_state    = wbit_pkg::ST_BREAK;
              end else if (n.cur_state == wbit_pkg::ST_BREAK) begin
                bd             = 1'b1;
                n.phase_total  = cfg.work_seconds;
                n.seconds_left = cfg.work_seconds;
                n.cur_state    = wbit_pkg::ST_WORK;
              end
            end
          end
        end
      end
      wbit_pkg::MODE_START: begin
        n.paused_by_idle = 1'b0;
        if (st.cur_state == wbit_pkg::ST_IDLE) begin
          n.phase_total  = cfg.work_seconds;
          n.seconds_left = cfg.work_seconds;
          n.cur_state    = wbit_pkg::ST_WORK;
          n.running      = 1'b1;
        end else if (st.cur_state == wbit_pkg::ST_PAUSE) begin
          n.cur_state = resume_to;
          n.running   = 1'b1;
        end
      end
      wbit_pkg::MODE_PAUSE: begin
        n.paused_by_idle = 1'b0;
        if (st.cur_state == wbit_pkg::ST_WORK || st.cur_state == wbit_pkg::ST_BREAK) begin
          n.running    = 1'b0;
          n.prev_state = st.cur_state;
          n.cur_state  = wbit_pkg::ST_PAUSE;
        end
      end
      wbit_pkg::MODE_RESUME: begin
        n.paused_by_idle = 1'b0;
        if (st.cur_state == wbit_pkg::ST_PAUSE) begin
          n.cur_state = resume_to;
          n.running   = 1'b1;
        end
      end
      wbit_pkg::MODE_STOP: begin
        n.paused_by_idle = 1'b0;
        n.running        = 1'b0;
        n.prev_state     = wbit_pkg::ST_IDLE;
        n.phase_total    = cfg.work_seconds;
        n.seconds_left   = cfg.work_seconds;
        n.cur_state      = wbit_pkg::ST_IDLE;
      end
      wbit_pkg::MODE_SKIP: begin
        if (st.cur_state == wbit_pkg::ST_BREAK ||
            (st.cur_state == wbit_pkg::ST_PAUSE && st.prev_state == wbit_pkg::ST_BREAK)) begin
          if (st.skipped != wbit_pkg::COUNT_MAX) begin
            n.skipped = st.skipped + 16'd1;
          end
          n.paused_by_idle = 1'b0;
          n.phase_total    = cfg.work_seconds;
          n.seconds_left   = cfg.work_seconds;
          n.cur_state      = wbit_pkg::ST_WORK;
          n.running        = 1'b1;
          sk_ev            = 1'b1;
        end
      end
      wbit_pkg::MODE_RELOAD: begin
        if (st.cur_state == wbit_pkg::ST_IDLE) begin
          n.phase_total  = cfg.work_seconds;
          n.seconds_left = cfg.work_seconds;
        end
      end
      default: begin
        // unused code: hold everything
      end
    endcase
  end

  assign st_nxt = n;

  always_comb begin
    res.run_state         = n.cur_state;
    res.remaining         = n.seconds_left;
    res.phase_length      = n.phase_total;
    res.idle_paused       = n.paused_by_idle;
    res.work_done         = wd;
    res.break_done        = bd;
    res.idle_pause_event  = ip_ev;
    res.idle_resume_event = ir_ev;
    res.skip_event        = sk_ev;
    res.breaks_completed  = n.completed;
    res.breaks_skipped    = n.skipped;
  end

endmodule

`default_nettype wire

// File: sv/work_break_interval_timer_top.sv
// ----------------------------------------------------------------------------
// work_break_interval_timer_top
// Work/break countdown timer driven by tick and control commands.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one command per transfer (mode, idle_ms). Every command,
//   a one-second tick included, yields exactly one transfer on out_ch with
//   the run state, remaining and total phase seconds, the event pulses and
//   the two saturating counters.
//   A command taken on in_ch lands in the input register; its result is
//   then held in the result register, which drives out_ch.
//   Throughput: one command per cycle while out_ch is not stalled; the single
//   state update sits between the input register and the result register.
//   A stalled out_ch holds its result; in_ch keeps accepting until the input
//   register is also occupied, then drops ready.
//   cfg_we/cfg_idx/cfg_wdata write the duration, idle enable and idle
//   threshold registers; write them only while no command is in flight.
//   The threshold is kept in milliseconds, converted when written.
//   Synchronous reset (rst_n low) returns the timer to idle with 1500 s work,
//   300 s break, idle detection off and both counters at zero.
// ----------------------------------------------------------------------------
`default_nettype none

module work_break_interval_timer_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  wbit_in_if.sink                             in_ch,
  wbit_out_if.source                          out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [wbit_pkg::CIDX_W-1:0]    cfg_idx,
  input  wire logic [wbit_pkg::CFG_W-1:0]     cfg_wdata
);

  wbit_pkg::cfg_t                  cfg_r;
  wbit_pkg::tstate_t               state_r;
  wbit_pkg::tstate_t               state_nxt;
  wbit_pkg::result_t               res_nxt;
  wbit_pkg::result_t               res_r;
  logic                            in_valid_r;
  logic [2:0]                      in_mode_r;
  logic [wbit_pkg::IDLE_W-1:0]     in_idle_r;
  logic                            out_valid_r;
  logic                            fire;
  logic                            in_take;

  assign fire    = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_take = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !in_valid_r || fire;

  wbit_step u_step (
    .st      (state_r),
    .cfg     (cfg_r),
    .mode    (in_mode_r),
    .idle_ms (in_idle_r),
    .st_nxt  (state_nxt),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.work_seconds   <= wbit_pkg::WORK_RST;
      cfg_r.break_seconds  <= wbit_pkg::BREAK_RST;
      cfg_r.idle_enable    <= 1'b0;
      cfg_r.idle_thr_ms    <= wbit_pkg::THR_RST;
      state_r.cur_state      <= wbit_pkg::ST_IDLE;
      state_r.prev_state     <= wbit_pkg::ST_IDLE;
      state_r.seconds_left   <= wbit_pkg::WORK_RST;
      state_r.phase_total    <= wbit_pkg::WORK_RST;
      state_r.paused_by_idle <= 1'b0;
      state_r.running        <= 1'b0;
      state_r.completed      <= '0;
      state_r.skipped        <= '0;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          wbit_pkg::CFG_WORK:    cfg_r.work_seconds  <= cfg_wdata;
          wbit_pkg::CFG_BREAK:   cfg_r.break_seconds <= cfg_wdata;
          wbit_pkg::CFG_IDLE_EN: cfg_r.idle_enable   <= cfg_wdata[0];
          wbit_pkg::CFG_IDLE_TH: begin
            cfg_r.idle_thr_ms <= wbit_pkg::THR_W'(cfg_wdata) * wbit_pkg::MS_PER_SEC;
          end
          default: begin
          end
        endcase
      end
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (fire) begin
        in_valid_r <= 1'b0;
      end
      if (fire) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_mode_r <= in_ch.mode;
      in_idle_r <= in_ch.idle_ms;
    end
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.run_state         = res_r.run_state;
  assign out_ch.remaining         = res_r.remaining;
  assign out_ch.phase_length      = res_r.phase_length;
  assign out_ch.idle_paused       = res_r.idle_paused;
  assign out_ch.work_done         = res_r.work_done;
  assign out_ch.break_done        = res_r.break_done;
  assign out_ch.idle_pause_event  = res_r.idle_pause_event;
  assign out_ch.idle_resume_event = res_r.idle_resume_event;
  assign out_ch.skip_event        = res_r.skip_event;
  assign out_ch.breaks_completed  = res_r.breaks_completed;
  assign out_ch.breaks_skipped    = res_r.breaks_skipped;

endmodule

`default_nettype wire

// File: sim/work_break_interval_timer_top_tb.sv
// ----------------------------------------------------------------------------
// work_break_interval_timer_top_tb
// Drives commands and ticks into the work/break timer under random idling of
// both channels, predicts every status transfer with a cycle-free model of
// the timer, and compares each one field by field. Covers directed corner
// cases and randomized traffic across several register settings.
// ----------------------------------------------------------------------------
module work_break_interval_timer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam int unsigned STALL_LIMIT = 1000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [wbit_pkg::CIDX_W-1:0] cfg_idx;
  logic [wbit_pkg::CFG_W-1:0] cfg_wdata;

  wbit_in_if in_ch ();
  wbit_out_if out_ch ();

  work_break_interval_timer_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Timer registers as the model sees them
  logic [wbit_pkg::SEC_W-1:0] reg_work;
  logic [wbit_pkg::SEC_W-1:0] reg_break;
  logic reg_idle_en;
  logic [wbit_pkg::SEC_W-1:0] reg_thr;

  // Timer state
  logic [1:0] tm_state;
  logic [1:0] tm_saved;
  logic [wbit_pkg::SEC_W-1:0] tm_left;
  logic [wbit_pkg::SEC_W-1:0] tm_total;
  logic tm_by_idle;
  logic tm_running;
  logic [wbit_pkg::SEC_W-1:0] tm_done_cnt;
  logic [wbit_pkg::SEC_W-1:0] tm_skip_cnt;

  wbit_pkg::result_t status_q[$];
  int unsigned errors = 0;
  int unsigned stall_cycles = 0;
  bit steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- model
  function automatic void load_phase(input logic [wbit_pkg::SEC_W-1:0] len);
    tm_total = len;
    tm_left = len;
  endfunction

  function automatic logic [1:0] resume_state();
    return (tm_saved == wbit_pkg::ST_IDLE) ? wbit_pkg::ST_WORK : tm_saved;
  endfunction

  function automatic void reset_timer();
    reg_work = wbit_pkg::WORK_RST;
    reg_break = wbit_pkg::BREAK_RST;
    reg_idle_en = 1'b0;
    reg_thr = wbit_pkg::THRSEC_RST;
    tm_state = wbit_pkg::ST_IDLE;
    tm_saved = wbit_pkg::ST_IDLE;
    load_phase(wbit_pkg::WORK_RST);
    tm_by_idle = 1'b0;
    tm_running = 1'b0;
    tm_done_cnt = '0;
    tm_skip_cnt = '0;
  endfunction

  function automatic wbit_pkg::result_t update_timer(input logic [2:0] mode,
                                                     input logic [31:0] idle_ms);
    wbit_pkg::result_t r;
    logic [63:0] thr_ms;
    r = '0;
    thr_ms = 64'(reg_thr) * 64'd1000;
    case (mode)
      wbit_pkg::MODE_TICK: begin
        if (tm_running) begin
          if (reg_idle_en) begin
            if (tm_state == wbit_pkg::ST_WORK && 64'(idle_ms) >= thr_ms) begin
              tm_by_idle = 1'b1;
              tm_saved = tm_state;
              tm_state = wbit_pkg::ST_PAUSE;
              r.idle_pause_event = 1'b1;
            end else if (tm_state == wbit_pkg::ST_PAUSE && tm_by_idle &&
                         idle_ms < wbit_pkg::IDLE_RES_MS) begin
              tm_by_idle = 1'b0;
              tm_state = resume_state();
              r.idle_resume_event = 1'b1;
            end
          end
          if (tm_state != wbit_pkg::ST_PAUSE) begin
            if (tm_left != 0) tm_left = tm_left - 16'd1;
            if (tm_left == 0) begin
              if (tm_state == wbit_pkg::ST_WORK) begin
                if (tm_done_cnt != wbit_pkg::COUNT_MAX) tm_done_cnt = tm_done_cnt + 16'd1;
                r.work_done = 1'b1;
                load_phase(reg_break);
                tm_state = wbit_pkg::ST_BREAK;
              end else if (tm_state == wbit_pkg::ST_BREAK) begin
                r.break_done = 1'b1;
                load_phase(reg_work);
                tm_state = wbit_pkg::ST_WORK;
              end
            end
          end
        end
      end
      wbit_pkg::MODE_START: begin
        tm_by_idle = 1'b0;
        if (tm_state == wbit_pkg::ST_IDLE) begin
          load_phase(reg_work);
          tm_state = wbit_pkg::ST_WORK;
          tm_running = 1'b1;
        end else if (tm_state == wbit_pkg::ST_PAUSE) begin
          tm_state = resume_state();
          tm_running = 1'b1;
        end
      end
      wbit_pkg::MODE_PAUSE: begin
        tm_by_idle = 1'b0;
        if (tm_state == wbit_pkg::ST_WORK || tm_state == wbit_pkg::ST_BREAK) begin
          tm_running = 1'b0;
          tm_saved = tm_state;
          tm_state = wbit_pkg::ST_PAUSE;
        end
      end
      wbit_pkg::MODE_RESUME: begin
        tm_by_idle = 1'b0;
        if (tm_state == wbit_pkg::ST_PAUSE) begin
          tm_state = resume_state();
          tm_running = 1'b1;
        end
      end
      wbit_pkg::MODE_STOP: begin
        tm_by_idle = 1'b0;
        tm_running = 1'b0;
        tm_saved = wbit_pkg::ST_IDLE;
        load_phase(reg_work);
        tm_state = wbit_pkg::ST_IDLE;
      end
      wbit_pkg::MODE_SKIP: begin
        if (tm_state == wbit_pkg::ST_BREAK ||
            (tm_state == wbit_pkg::ST_PAUSE && tm_saved == wbit_pkg::ST_BREAK)) begin
          if (tm_skip_cnt != wbit_pkg::COUNT_MAX) tm_skip_cnt = tm_skip_cnt + 16'd1;
          tm_by_idle = 1'b0;
          load_phase(reg_work);
          tm_state = wbit_pkg::ST_WORK;
          tm_running = 1'b1;
          r.skip_event = 1'b1;
        end
      end
      wbit_pkg::MODE_RELOAD: begin
        if (tm_state == wbit_pkg::ST_IDLE) load_phase(reg_work);
      end
      default: ;
    endcase
    r.run_state = tm_state;
    r.remaining = tm_left;
    r.phase_length = tm_total;
    r.idle_paused = tm_by_idle;
    r.breaks_completed = tm_done_cnt;
    r.breaks_skipped = tm_skip_cnt;
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers
  // Every driver task starts and ends at a falling edge.
  task automatic send_cmd(input logic [2:0] mode, input logic [31:0] idle_ms);
    int unsigned gap;
    gap = 0;
    while (!steady && $urandom_range(99) < 32) gap++;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.idle_ms <= idle_ms;
    do @(posedge clk); while (!in_ch.ready);
    status_q.push_back(update_timer(mode, idle_ms));
    @(negedge clk);
  endtask

  // Hold the command channel until every pending status has been transferred.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (status_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_config(input logic [wbit_pkg::SEC_W-1:0] work_s,
                              input logic [wbit_pkg::SEC_W-1:0] break_s,
                              input logic en, input logic [wbit_pkg::SEC_W-1:0] thr_s);
    logic [wbit_pkg::CFG_W-1:0] vals [4];
    logic [wbit_pkg::CIDX_W-1:0] idxs [4];
    vals = '{work_s, break_s, {15'd0, en}, thr_s};
    idxs = '{wbit_pkg::CFG_WORK, wbit_pkg::CFG_BREAK, wbit_pkg::CFG_IDLE_EN,
             wbit_pkg::CFG_IDLE_TH};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= idxs[i];
      cfg_wdata <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    reg_work = work_s;
    reg_break = break_s;
    reg_idle_en = en;
    reg_thr = thr_s;
  endtask

  function automatic logic [wbit_pkg::SEC_W-1:0] pick_len();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) return wbit_pkg::COUNT_MAX;
    if (sel < 8) return wbit_pkg::SEC_W'($urandom_range(4));
    return wbit_pkg::SEC_W'($urandom);
  endfunction

  task automatic send_random_cmd();
    logic [2:0] mode;
    logic [31:0] idle_ms;
    int unsigned pick;
    int unsigned sel;
    pick = $urandom_range(99);
    if (pick < 55) mode = wbit_pkg::MODE_TICK;
    else if (pick < 63) mode = wbit_pkg::MODE_START;
    else if (pick < 70) mode = wbit_pkg::MODE_PAUSE;
    else if (pick < 78) mode = wbit_pkg::MODE_RESUME;
    else if (pick < 82) mode = wbit_pkg::MODE_STOP;
    else if (pick < 90) mode = wbit_pkg::MODE_SKIP;
    else if (pick < 97) mode = wbit_pkg::MODE_RELOAD;
    else mode = MODE_UNUSED;
    // get past idle quickly so most traffic exercises a running timer
    if (tm_state == wbit_pkg::ST_IDLE && $urandom_range(1) == 1) mode = wbit_pkg::MODE_START;
    sel = $urandom_range(9);
    if (sel < 4) idle_ms = $urandom_range(2500);
    else if (sel < 7) idle_ms = reg_thr * 32'd1000 + $urandom_range(2) - 32'd1;
    else if (sel < 9) idle_ms = $urandom;
    else idle_ms = ($urandom_range(1) == 1) ? '1 : '0;
    send_cmd(mode, idle_ms);
  endtask

  // ---------------------------------------------------------------- sink
  always @(negedge clk) begin
    out_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= 32);
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_status
    wbit_pkg::result_t got;
    wbit_pkg::result_t want;
    if (out_ch.valid && out_ch.ready) begin
      got = {out_ch.run_state, out_ch.remaining, out_ch.phase_length, out_ch.idle_paused,
             out_ch.work_done, out_ch.break_done, out_ch.idle_pause_event,
             out_ch.idle_resume_event, out_ch.skip_event, out_ch.breaks_completed,
             out_ch.breaks_skipped};
      if (status_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected status transfer, expected none actual %h", $time, got);
      end else begin
        want = status_q.pop_front();
        check_field("run_state", want.run_state, got.run_state);
        check_field("remaining", want.remaining, got.remaining);
        check_field("phase_length", want.phase_length, got.phase_length);
        check_field("idle_paused", want.idle_paused, got.idle_paused);
        check_field("work_done", want.work_done, got.work_done);
        check_field("break_done", want.break_done, got.break_done);
        check_field("idle_pause_event", want.idle_pause_event, got.idle_pause_event);
        check_field("idle_resume_event", want.idle_resume_event, got.idle_resume_event);
        check_field("skip_event", want.skip_event, got.skip_event);
        check_field("breaks_completed", want.breaks_completed, got.breaks_completed);
        check_field("breaks_skipped", want.breaks_skipped, got.breaks_skipped);
      end
    end
  end

  // Abort when neither channel completes a transfer for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_stopped_commands();
    send_cmd(wbit_pkg::MODE_TICK, 32'd0);
    send_cmd(wbit_pkg::MODE_TICK, 32'hFFFF_FFFF);
    send_cmd(wbit_pkg::MODE_RELOAD, 32'd0);
    send_cmd(MODE_UNUSED, 32'd0);
    send_cmd(wbit_pkg::MODE_PAUSE, 32'd0);
    send_cmd(wbit_pkg::MODE_RESUME, 32'd0);
    send_cmd(wbit_pkg::MODE_SKIP, 32'd0);
  endtask

  task automatic test_phase_turnover();
    apply_config(16'd0, 16'd0, 1'b0, 16'd300);
    send_cmd(wbit_pkg::MODE_START, 32'd0);
    send_cmd(wbit_pkg::MODE_TICK, 32'd0);
    send_cmd(wbit_pkg::MODE_TICK, 32'd0);
    send_cmd(wbit_pkg::MODE_TICK, 32'd0);
    send_cmd(wbit_pkg::MODE_PAUSE, 32'd0);
    send_cmd(wbit_pkg::MODE_SKIP, 32'd0);
    send_cmd(wbit_pkg::MODE_STOP, 32'd0);
    send_cmd(wbit_pkg::MODE_RELOAD, 32'd0);
  endtask

  task automatic test_idle_detection();
    // threshold zero pauses every running work tick
    apply_config(wbit_pkg::COUNT_MAX, wbit_pkg::COUNT_MAX, 1'b1, 16'd0);
    send_cmd(wbit_pkg::MODE_START, 32'd0);
    send_cmd(wbit_pkg::MODE_TICK, 32'd0);
    send_cmd(wbit_pkg::MODE_TICK, 32'd1999);
    send_cmd(wbit_pkg::MODE_TICK, 32'hFFFF_FFFF);
    send_cmd(wbit_pkg::MODE_PAUSE, 32'd0);
    send_cmd(wbit_pkg::MODE_TICK, 32'd0);
    send_cmd(wbit_pkg::MODE_RESUME, 32'd0);
    send_cmd(wbit_pkg::MODE_STOP, 32'd0);
    apply_config(wbit_pkg::COUNT_MAX, wbit_pkg::COUNT_MAX, 1'b1, wbit_pkg::COUNT_MAX);
    send_cmd(wbit_pkg::MODE_START, 32'd0);
    send_cmd(wbit_pkg::MODE_TICK, 32'hFFFF_FFFF);
    send_cmd(wbit_pkg::MODE_TICK, 32'd2000);
    send_cmd(wbit_pkg::MODE_TICK, 32'd1999);
    send_cmd(wbit_pkg::MODE_STOP, 32'd0);
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 5; phase++) begin
      apply_config(pick_len(), pick_len(), 1'($urandom_range(1)), pick_len());
      steady = (phase == 2);
      for (int i = 0; i < 124; i++) begin
        if (i == 62) wait_idle();
        send_random_cmd();
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = wbit_pkg::MODE_TICK;
    in_ch.idle_ms = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = wbit_pkg::CFG_WORK;
    cfg_wdata = '0;
    rst_n = 1'b0;
    reset_timer();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_stopped_commands();
    test_phase_turnover();
    test_idle_detection();
    test_random_traffic();
    wait_idle();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
